// ===== hdl/prr_pkg.sv =====
// Package: shared constants, codes and types of the polyphase rational resampler.
`timescale 1ns / 1ps
package prr_pkg;

	// Storage sizes and limits
	localparam int COEF_DEPTH = 8192;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);
	localparam int HIST_DEPTH = 1024;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int MAX_RATIO  = 64;
	localparam int RATIO_SH   = $clog2(MAX_RATIO);
	localparam int MAX_BURST  = 64;
	localparam int BURST_W    = $clog2(MAX_BURST + 1);

	// Field and register widths
	localparam int CMD_W    = 2;
	localparam int COEF_W   = 18;
	localparam int SAMPLE_W = 16;
	localparam int UP_W     = 11;
	localparam int DN_W     = 11;
	localparam int HALF_W   = 12;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 12;

	// Datapath widths
	localparam int CNT_W  = 32;
	localparam int PROD_W = CNT_W + UP_W;
	localparam int POS_W  = PROD_W + 1;
	localparam int TAP_W  = HALF_W + 2;
	localparam int MUL_W  = SAMPLE_W + COEF_W;
	localparam int ACC_W  = MUL_W + COEF_AW + 1;
	localparam int SCL_W  = ACC_W + UP_W + 1;
	localparam int FRAC_SH = COEF_W - 1;

	// Item commands
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_UP   = 2'd0;
	localparam logic [CFG_AW-1:0] REG_DOWN = 2'd1;
	localparam logic [CFG_AW-1:0] REG_HALF = 2'd2;

	// Result status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] dividend;
		logic [UP_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [POS_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/prr_if.sv =====
// Interfaces: input item channel, result channel and configuration write channel.
`timescale 1ns / 1ps
interface prr_item_if import prr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           cmd;
	logic [COEF_AW-1:0]         coef_index;
	logic signed [COEF_W-1:0]   coef_value;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       end_of_stream;
	modport source (output valid, cmd, coef_index, coef_value, sample_value, end_of_stream,
		input ready);
	modport sink (input valid, cmd, coef_index, coef_value, sample_value, end_of_stream,
		output ready);
endinterface

interface prr_res_if import prr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       last_of_run;
	logic                       stream_done;
	logic                       status;
	modport source (output valid, sample_out, last_of_run, stream_done, status, input ready);
	modport sink (input valid, sample_out, last_of_run, stream_done, status, output ready);
endinterface

interface prr_cfg_if import prr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/prr_div.sv =====
// Restoring divider: one quotient bit per cycle, finds floor(dividend / divisor).
`timescale 1ns / 1ps
module prr_div import prr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(POS_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [UP_W-1:0]   rem_q;
	logic [POS_W-1:0]  quo_q;
	logic [UP_W:0]     trial;
	logic              fits;

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[POS_W-1]};
	assign fits  = trial >= {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= req.dividend;
			end else if (run_q) begin
				rem_q <= fits ? UP_W'(trial - {1'b0, req.divisor}) : UP_W'(trial);
				quo_q <= {quo_q[POS_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hdl/polyphase_rational_resampler_top.sv =====
// Top level: polyphase rational L/M resampler with a shared multiply-accumulate sequencer.
//
//  channel  | role        | contents
//  ---------+-------------+----------------------------------------------------------
//  item     | sink        | cmd, coef_index, coef_value, sample_value, end_of_stream
//  result   | source      | sample_out, last_of_run, stream_done, status
//  cfg      | sink        | index (0 up, 1 down, 2 half taps), data
//
//  Loads and ignored items leave the sequencer idle; a pass-through push goes to send.
//  A filtered output runs the readiness check, the serial divider, the tap setup, then
//  a read, multiply and accumulate per tap on a stored sample (about 2*half_taps/L taps),
//  scaling, rounding, send. An item yields up to 64 outputs; item ready is low meanwhile.
//  A stalled result holds the sequencer in its send step. Reset clears the counters and
//  the registers to L = M = 1, half taps 0; no memory clearing pass is needed.
`timescale 1ns / 1ps
module polyphase_rational_resampler_top import prr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	prr_item_if.sink  item,
	prr_res_if.source result,
	prr_cfg_if.sink   cfg
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK1 = 4'd1;
	localparam logic [3:0] S_CHK2 = 4'd2;
	localparam logic [3:0] S_DVS  = 4'd3;
	localparam logic [3:0] S_DVW  = 4'd4;
	localparam logic [3:0] S_TAP0 = 4'd5;
	localparam logic [3:0] S_TAP1 = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_MUL  = 4'd8;
	localparam logic [3:0] S_ACC  = 4'd9;
	localparam logic [3:0] S_SCL  = 4'd10;
	localparam logic [3:0] S_RND  = 4'd11;
	localparam logic [3:0] S_SEND = 4'd12;

	logic [3:0]               state_q;
	logic [UP_W-1:0]          up_q;
	logic [DN_W-1:0]          dn_q;
	logic [HALF_W-1:0]        half_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         sent_q;
	logic                     ended_q;
	logic [BURST_W-1:0]       k_q;
	logic                     pending_q;
	logic                     go_on_q;
	logic [PROD_W-1:0]        im_q;
	logic [PROD_W-1:0]        nl_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         j_q;
	logic [PROD_W-1:0]        jl_q;
	logic [TAP_W-1:0]         tap_q;
	logic signed [MUL_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SCL_W-1:0]  scl_q;
	logic signed [SAMPLE_W-1:0] res_sample_q;
	logic                     res_last_q;
	logic                     res_done_q;
	logic                     res_status_q;
	logic                     out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                     out_last_q;
	logic                     out_done_q;
	logic                     out_status_q;

	logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
	logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
	logic signed [COEF_W-1:0]   coef_rd_q;
	logic signed [SAMPLE_W-1:0] hist_rd_q;

	logic item_acc;
	logic reject;
	logic push_ok;
	logic push_we;
	logic same_rate;
	logic out_free;
	logic [POS_W-1:0]    pos_d;
	logic                avail_d;
	logic                next_ok;
	logic [CNT_W-1:0]    oldest;
	logic [CNT_W-1:0]    n_last;
	logic [TAP_W-1:0]    tap_lim;
	logic [POS_W-1:0]    tap_full;
	logic [TAP_W-1:0]    tap_nx;
	logic signed [SCL_W-1:0] rnd_d;
	logic signed [SAMPLE_W-1:0] sat_d;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Handshake and item decode
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_acc   = item.valid && item.ready;
	assign reject     = (up_q == '0) || (dn_q == '0) ||
		({{RATIO_SH{1'b0}}, up_q} > {dn_q, {RATIO_SH{1'b0}}});
	assign same_rate  = (up_q == dn_q);
	assign push_ok    = !ended_q && (n_q != '1);
	assign push_we    = item_acc && (item.cmd == CMD_PUSH) && !reject && push_ok;
	assign out_free   = !out_valid_q || result.ready;

	// Readiness of output number sent_q: i*M + h < n*L, or i*M < n*L after the end
	assign pos_d   = POS_W'(im_q) + POS_W'(half_q);
	assign avail_d = ended_q ? (im_q < nl_q) : ((n_q != '0) && (pos_d < POS_W'(nl_q)));
	assign next_ok = (sent_q != '1) && avail_d && (k_q < BURST_W'(MAX_BURST));

	// Tap window bounds
	assign oldest   = (n_q > CNT_W'(HIST_DEPTH)) ? n_q - CNT_W'(HIST_DEPTH) : '0;
	assign n_last   = n_q - 1'b1;
	assign tap_lim  = TAP_W'({half_q, 1'b0});
	assign tap_full = pos_q - POS_W'(jl_q);
	assign tap_nx   = tap_q + TAP_W'(up_q);

	// Round half up and saturate
	assign rnd_d = (scl_q + SCL_W'(65536)) >>> FRAC_SH;
	always_comb begin
		if (rnd_d > 60'sd32767)
			sat_d = 16'sh7fff;
		else if (rnd_d < -60'sd32768)
			sat_d = -16'sh8000;
		else
			sat_d = SAMPLE_W'(rnd_d);
	end

	// Shared divider for the newest tap position
	assign div_req.start    = (state_q == S_DVS);
	assign div_req.dividend = pos_q;
	assign div_req.divisor  = up_q;

	prr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Coefficient store
	always_ff @(posedge clk) begin
		if (item_acc && item.cmd == CMD_LOAD)
			coef_mem[item.coef_index] <= item.coef_value;
		if (state_q == S_RD)
			coef_rd_q <= coef_mem[tap_q[COEF_AW-1:0]];
	end

	// Sample history ring
	always_ff @(posedge clk) begin
		if (push_we)
			hist_mem[n_q[HIST_AW-1:0]] <= item.sample_value;
		if (state_q == S_RD)
			hist_rd_q <= hist_mem[j_q[HIST_AW-1:0]];
	end

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			up_q         <= UP_W'(1);
			dn_q         <= DN_W'(1);
			half_q       <= '0;
			n_q          <= '0;
			sent_q       <= '0;
			ended_q      <= 1'b0;
			k_q          <= '0;
			pending_q    <= 1'b0;
			go_on_q      <= 1'b0;
			im_q         <= '0;
			nl_q         <= '0;
			pos_q        <= '0;
			j_q          <= '0;
			jl_q         <= '0;
			tap_q        <= '0;
			prod_q       <= '0;
			acc_q        <= '0;
			scl_q        <= '0;
			res_sample_q <= '0;
			res_last_q   <= 1'b0;
			res_done_q   <= 1'b0;
			res_status_q <= STATUS_OK;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_UP:   up_q   <= cfg.data[UP_W-1:0];
					REG_DOWN: dn_q   <= cfg.data[DN_W-1:0];
					REG_HALF: half_q <= cfg.data[HALF_W-1:0];
					default:  ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (item_acc && (item.cmd == CMD_PUSH || item.cmd == CMD_FLUSH)) begin
						k_q       <= '0;
						pending_q <= 1'b0;
						if (reject) begin
							res_sample_q <= '0;
							res_last_q   <= 1'b1;
							res_done_q   <= 1'b0;
							res_status_q <= STATUS_REJECT;
							go_on_q      <= 1'b0;
							state_q      <= S_SEND;
						end else if (item.cmd == CMD_FLUSH) begin
							if (ended_q || n_q != '0) begin
								ended_q <= 1'b1;
								if (!same_rate)
									state_q <= S_CHK1;
							end
						end else if (push_ok) begin
							n_q     <= n_q + 1'b1;
							ended_q <= item.end_of_stream;
							if (!same_rate) begin
								state_q <= S_CHK1;
							end else if (sent_q != '1) begin
								res_sample_q <= item.sample_value;
								res_last_q   <= 1'b1;
								res_done_q   <= item.end_of_stream;
								res_status_q <= STATUS_OK;
								sent_q       <= sent_q + 1'b1;
								go_on_q      <= 1'b0;
								state_q      <= S_SEND;
							end
						end
					end
				end
				S_CHK1: begin
					im_q    <= PROD_W'(sent_q) * PROD_W'(dn_q);
					nl_q    <= PROD_W'(n_q) * PROD_W'(up_q);
					state_q <= S_CHK2;
				end
				S_CHK2: begin
					pos_q <= pos_d;
					if (pending_q) begin
						// Flags of the held output follow from the next one's readiness
						pending_q    <= 1'b0;
						res_last_q   <= !next_ok;
						res_done_q   <= ended_q && !(im_q < nl_q);
						res_status_q <= STATUS_OK;
						go_on_q      <= next_ok;
						state_q      <= S_SEND;
					end else begin
						state_q <= next_ok ? S_DVS : S_IDLE;
					end
				end
				S_DVS: state_q <= S_DVW;
				S_DVW: begin
					if (div_rsp.done) begin
						j_q <= (div_rsp.quotient > POS_W'(n_last)) ? n_last :
							div_rsp.quotient[CNT_W-1:0];
						state_q <= S_TAP0;
					end
				end
				S_TAP0: begin
					jl_q    <= PROD_W'(j_q) * PROD_W'(up_q);
					state_q <= S_TAP1;
				end
				S_TAP1: begin
					acc_q   <= '0;
					tap_q   <= tap_full[TAP_W-1:0];
					state_q <= (tap_full <= POS_W'(tap_lim) && j_q >= oldest) ? S_RD : S_SCL;
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: begin
					prod_q  <= hist_rd_q * coef_rd_q;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (tap_nx <= tap_lim && j_q > oldest) begin
						tap_q   <= tap_nx;
						j_q     <= j_q - 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_SCL;
					end
				end
				S_SCL: begin
					scl_q   <= SCL_W'(acc_q) * $signed(SCL_W'({1'b0, up_q}));
					state_q <= S_RND;
				end
				S_RND: begin
					res_sample_q <= sat_d;
					sent_q       <= sent_q + 1'b1;
					k_q          <= k_q + 1'b1;
					pending_q    <= 1'b1;
					state_q      <= S_CHK1;
				end
				S_SEND: begin
					if (out_free)
						state_q <= go_on_q ? S_DVS : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_last_q   <= 1'b0;
			out_done_q   <= 1'b0;
			out_status_q <= STATUS_OK;
		end else if (state_q == S_SEND && out_free) begin
			out_valid_q  <= 1'b1;
			out_sample_q <= res_sample_q;
			out_last_q   <= res_last_q;
			out_done_q   <= res_done_q;
			out_status_q <= res_status_q;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.sample_out  = out_sample_q;
	assign result.last_of_run = out_last_q;
	assign result.stream_done = out_done_q;
	assign result.status      = out_status_q;

endmodule

// ===== hdl/prr_chk.sv =====
// Port checker for the resampler top level, attached by bind.
`timescale 1ns / 1ps
module prr_chk import prr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input logic [SAMPLE_W-1:0] res_sample,
	input logic                res_last,
	input logic                res_done,
	input logic                res_status
);

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_sample) && $stable(res_last) &&
			$stable(res_done) && $stable(res_status))
		else $error("result payload changed while stalled");

	// A rejection is a lone zero result that ends its run
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_REJECT |->
			res_last && !res_done && res_sample == '0)
		else $error("malformed rejection result");

	// The last output of the stream is always the last of its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_done |-> res_last)
		else $error("stream end not marked as end of run");

endmodule

bind polyphase_rational_resampler_top prr_chk u_prr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_sample (result.sample_out),
	.res_last   (result.last_of_run),
	.res_done   (result.stream_done),
	.res_status (result.status)
);

// ===== tb/sv/prr_scoreboard.sv =====
// Checker: watches the item, config and result channels, predicts results and compares.
`timescale 1ns / 1ps
module prr_scoreboard import prr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	prr_item_if.sink item,
	prr_res_if.sink  result,
	prr_cfg_if.sink  cfg,
	output int       fail_count,
	output int       pending,
	output int       results_seen
);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		logic                       done;
		logic                       status;
	} res_t;

	// Predictor state
	logic signed [COEF_W-1:0]   taps [COEF_DEPTH];
	logic signed [SAMPLE_W-1:0] hist [HIST_DEPTH];
	longint unsigned n_in, n_out;
	bit ended;
	longint unsigned up_f, dn_f, half_n;
	res_t expected_q[$];

	assign pending = expected_q.size();

	function automatic longint unsigned total_out();
		return (n_in * up_f + dn_f - 1) / dn_f;
	endfunction

	function automatic bit out_ready(longint unsigned i);
		if (n_out == 64'hFFFF_FFFF) return 0;
		if (ended) return i < total_out();
		if (n_in == 0) return 0;
		return (i * dn_f + half_n) / up_f < n_in;
	endfunction

	// Filtered output number i, scaled by L, rounded and saturated
	function automatic logic signed [SAMPLE_W-1:0] filter_out(longint unsigned i);
		longint unsigned im, pos, jhi, jlo, oldest, tap;
		longint acc, r;
		im = i * dn_f;
		pos = im + half_n;
		jhi = pos / up_f;
		jlo = 0;
		acc = 0;
		if (n_in == 0) return '0;
		if (jhi > n_in - 1) jhi = n_in - 1;
		if (im > half_n) jlo = (im - half_n + up_f - 1) / up_f;
		oldest = (n_in > HIST_DEPTH) ? n_in - HIST_DEPTH : 0;
		if (jlo < oldest) jlo = oldest;
		for (longint unsigned j = jlo; j <= jhi; j++) begin
			tap = pos - j * up_f;
			if (tap < COEF_DEPTH)
				acc += longint'(hist[j % HIST_DEPTH]) * longint'(taps[tap]);
		end
		acc = acc * longint'(up_f) + 65536;
		r = acc >>> FRAC_SH;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[SAMPLE_W-1:0];
	endfunction

	task automatic push_expected(logic signed [SAMPLE_W-1:0] s, bit last, bit done, bit st);
		res_t r;
		r.sample = s;
		r.last = last;
		r.done = done;
		r.status = st;
		expected_q.push_back(r);
	endtask

	task automatic emit_burst();
		int k;
		bit dn;
		k = 0;
		while (k < MAX_BURST && out_ready(n_out)) begin
			dn = ended && (n_out + 1 == total_out());
			push_expected(filter_out(n_out), 0, dn, STATUS_OK);
			n_out++;
			k++;
		end
		if (k > 0) expected_q[$].last = 1;
	endtask

	task automatic predict_item();
		if (item.cmd == CMD_LOAD) begin
			taps[item.coef_index] = item.coef_value;
			return;
		end
		if (item.cmd != CMD_PUSH && item.cmd != CMD_FLUSH) return;
		if (up_f == 0 || dn_f == 0 || up_f > MAX_RATIO * dn_f) begin
			push_expected('0, 1, 0, STATUS_REJECT);
			return;
		end
		if (item.cmd == CMD_FLUSH) begin
			if (!ended) begin
				if (n_in == 0) return;
				ended = 1;
			end
			if (up_f != dn_f) emit_burst();
			return;
		end
		if (ended || n_in == 64'hFFFF_FFFF) return;
		hist[n_in % HIST_DEPTH] = item.sample_value;
		n_in++;
		if (item.end_of_stream) ended = 1;
		if (up_f == dn_f) begin
			if (n_out == 64'hFFFF_FFFF) return;
			push_expected(item.sample_value, 1, ended, STATUS_OK);
			n_out++;
		end else begin
			emit_burst();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			n_in = 0;
			n_out = 0;
			ended = 0;
			up_f = 1;
			dn_f = 1;
			half_n = 0;
			expected_q.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			// Check a result transfer against the oldest expectation
			if (result.valid && result.ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: unexpected result sample=%0d", result.sample_out);
				end else begin
					e = expected_q.pop_front();
					if (e.sample !== result.sample_out || e.last !== result.last_of_run ||
						e.done !== result.stream_done || e.status !== result.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: exp s=%0d l=%0b d=%0b st=%0b got s=%0d l=%0b d=%0b st=%0b",
								e.sample, e.last, e.done, e.status, result.sample_out,
								result.last_of_run, result.stream_done, result.status);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_UP: up_f = cfg.data[UP_W-1:0];
					REG_DOWN: dn_f = cfg.data[DN_W-1:0];
					REG_HALF: half_n = cfg.data[HALF_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) predict_item();
		end
	end

endmodule

// ===== tb/sv/tb_polyphase_rational_resampler_top.sv =====
// Testbench top: clock, reset, stimulus, stall patterns, watchdog and verdict.
`timescale 1ns / 1ps
module tb_polyphase_rational_resampler_top;
	import prr_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk;
	logic arst_n;
	int   fail_count, pending, results_seen;
	int   src_idle_pct, snk_stall_pct;
	bit   long_hold;
	int   idle_cycles;
	int   items_sent;
	int   n_cfg;

	prr_item_if item_ch ();
	prr_res_if  res_ch ();
	prr_cfg_if  cfg_ch ();

	polyphase_rational_resampler_top dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(res_ch.source),
		.cfg(cfg_ch.sink)
	);

	prr_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(res_ch.sink),
		.cfg(cfg_ch.sink), .fail_count(fail_count), .pending(pending),
		.results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Result side: random stalls, plus one long hold-off
	initial begin
		res_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (long_hold) res_ch.ready <= 0;
			else res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Watchdog: cycles with no transfer on any channel
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results pending", pending);
				$display("tb_polyphase_rational_resampler_top NOT OK");
				$finish;
			end
		end
	end

	// Leaves valid high after the transfer; the next item replaces it or drain() takes it down
	task automatic send_item(logic [CMD_W-1:0] c, logic [COEF_AW-1:0] idx,
		logic signed [COEF_W-1:0] cv, logic signed [SAMPLE_W-1:0] sv, logic eos);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 0;
			@(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.cmd <= c;
		item_ch.coef_index <= idx;
		item_ch.coef_value <= cv;
		item_ch.sample_value <= sv;
		item_ch.end_of_stream <= eos;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	task automatic push(logic signed [SAMPLE_W-1:0] s, logic eos);
		send_item(CMD_PUSH, COEF_AW'($urandom), COEF_W'($urandom), s, eos);
	endtask

	task automatic drain();
		item_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (4000) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] d);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		n_cfg++;
	endtask

	task automatic set_ratio(int up, int dn, int half);
		write_reg(REG_UP, CFG_DW'(up));
		write_reg(REG_DOWN, CFG_DW'(dn));
		write_reg(REG_HALF, CFG_DW'(half));
		cfg_ch.valid <= 0;
	endtask

	// Load all 2*half+1 taps with random values
	task automatic load_taps(int half);
		for (int t = 0; t <= 2 * half; t++)
			send_item(CMD_LOAD, COEF_AW'(t), COEF_W'($urandom), '0, 1'b0);
	endtask

	initial begin
		int up, dn, half, len;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		long_hold = 0;
		items_sent = 0;
		n_cfg = 0;
		item_ch.valid = 0;
		item_ch.cmd = CMD_LOAD;
		item_ch.coef_index = 0;
		item_ch.coef_value = 0;
		item_ch.sample_value = 0;
		item_ch.end_of_stream = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_UP;
		cfg_ch.data = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: pass-through at reset ratio, extremes of samples
		push(16'sh7FFF, 1'b0);
		push(-16'sh8000, 1'b0);
		push(16'sh0001, 1'b0);
		push(16'sh1234, 1'b0);
		send_item(CMD_RSVD, '0, '0, '0, 1'b0);
		// Coefficient extremes at both ends of the store
		send_item(CMD_LOAD, 13'h1FFF, -18'sh20000, '0, 1'b0);
		send_item(CMD_LOAD, 13'd0, 18'sh1FFFF, '0, 1'b0);
		send_item(CMD_LOAD, 13'd1, -18'sh20000, '0, 1'b0);
		send_item(CMD_LOAD, 13'd2, 18'sh1FFFF, '0, 1'b0);
		drain();
		// Rejected ratios: zero factor and beyond 64x
		set_ratio(0, 1, 1);
		push(16'sd5, 1'b0);
		send_item(CMD_FLUSH, '0, '0, '0, 1'b0);
		drain();
		set_ratio(65, 1, 1);
		push(16'sd5, 1'b0);
		drain();
		set_ratio(64, 1, 1);
		drain();

		// Random phases; stream state persists until reset, so ratio changes
		// only apply to the one ongoing stream; end it late with a flush.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 68; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 68; end
				default: begin src_idle_pct = 26; snk_stall_pct = 26; end
			endcase
			up = $urandom_range(1, 7);
			dn = $urandom_range(1, 7);
			half = $urandom_range(0, 4);
			if (ph == 0) begin up = 1024; dn = 1024; half = 4095; end
			// Highest ratio so the long hold-off meets a steady flow of outputs
			if (ph == 2) begin up = 7; dn = 1; half = 2; end
			if (ph == 7) begin up = 1; dn = 7; half = 0; end
			set_ratio(up, dn, half);
			if (half < 100) load_taps(half);
			else send_item(CMD_LOAD, COEF_AW'($urandom), COEF_W'($urandom), '0, 1'b0);
			len = 32;
			if (ph == 2) fork
				begin
					long_hold = 1;
					repeat (1500) @(posedge clk);
					long_hold = 0;
				end
			join_none
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(9) == 0)
					send_item(CMD_LOAD, COEF_AW'($urandom_range(0, 2 * half)),
						COEF_W'($urandom), '0, 1'b0);
				else push(SAMPLE_W'($urandom), 1'b0);
			end
			drain();
		end
		// End of the stream, flushes to take the tail, then pushes after the end
		push(-16'sh8000, 1'b1);
		send_item(CMD_FLUSH, '0, '0, '0, 1'b0);
		send_item(CMD_FLUSH, '0, '0, '0, 1'b0);
		push(16'sd7, 1'b0);
		push(16'sd7, 1'b1);
		drain();

		if (long_hold) wait (!long_hold);
		$display("Ran %0d items and %0d register writes, %0d results checked", items_sent,
			n_cfg, results_seen);
		$display("covered pass-through, rejection, filtering ratios, stalls and stream end");
		if (fail_count == 0 && pending == 0)
			$display("tb_polyphase_rational_resampler_top OK");
		else
			$display("tb_polyphase_rational_resampler_top NOT OK");
		$finish;
	end

endmodule
